@@ hw/rtl/urrc_pkg.sv @@
// urrc_pkg: shared types, constants and register codes of the ultrasonic ranger
// and relay control; used by urrc_front, urrc_back and the top level
package urrc_pkg;

    // defaults for top-level parameters
    localparam int COUNT_BITS_DEF = 20;
    localparam int Q_DEPTH_DEF    = 4;

    // field widths
    localparam int C2D_W    = 16;
    localparam int TRIG_W   = 16;
    localparam int TMO_W    = 20;
    localparam int DIST_W   = 13;
    localparam int GAIN_W   = 16;
    localparam int PCT_W    = 7;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam int CMP_W    = 32;

    // fixed-point shifts
    localparam int D_SHIFT  = 12;
    localparam int P_SHIFT  = 16;

    // distance clamp in 1/16 cm and full-scale percent
    localparam logic [DIST_W-1:0] DIST_MIN_Q4 = 13'd32;
    localparam logic [DIST_W-1:0] DIST_MAX_Q4 = 13'd6400;
    localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;

    // register reset values
    localparam logic [C2D_W-1:0]  C2D_RST       = 16'd696;
    localparam logic [TRIG_W-1:0] TRIG_LOW_RST  = 16'd32;
    localparam logic [TRIG_W-1:0] TRIG_HIGH_RST = 16'd160;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST   = 20'd100000;
    localparam logic [DIST_W-1:0] THR_LOW_RST   = 13'd96;
    localparam logic [DIST_W-1:0] THR_HIGH_RST  = 13'd240;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd27307;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_C2D       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd6;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FORCE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    // measurement phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_LOW,
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_HIGH,
        PH_MEASURE
    } t_phase;

    // back-end sequencer: one step per beat, three more for a reading
    typedef enum logic [1:0] {
        SQ_STEP,
        SQ_MUL1,
        SQ_MUL2,
        SQ_FIN
    } t_seq;

    // classified input beat
    typedef struct packed {
        logic start;
        logic force_off;
        logic clr_ovr;
        logic echo;
    } t_cmd;

    // configuration registers
    typedef struct packed {
        logic [C2D_W-1:0]  c2d;
        logic [TRIG_W-1:0] trig_low;
        logic [TRIG_W-1:0] trig_high;
        logic [TMO_W-1:0]  timeout;
        logic [DIST_W-1:0] thr_low;
        logic [DIST_W-1:0] thr_high;
        logic [GAIN_W-1:0] gain;
    } t_cfg;

    // result beat
    typedef struct packed {
        logic              trigger_out;
        logic              relay_on;
        logic              override_on;
        logic              busy_res;
        logic              done_res;
        logic              ok;
        logic [DIST_W-1:0] distance_q4;
        logic [PCT_W-1:0]  percent;
    } t_result;

endpackage

@@ hw/rtl/urrc_front.sv @@
// urrc_front: input queue of the ranger; decodes each request into a command
// and holds it until the back end takes it; depends on urrc_pkg
module urrc_front #(
    parameter int Q_DEPTH = urrc_pkg::Q_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [urrc_pkg::REQ_W-1:0] i_req_type,
    input  logic                       i_echo_level,
    output urrc_pkg::t_cmd             o_cmd,
    output logic                       o_cmd_vld,
    input  logic                       i_cmd_pop
);
    import urrc_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cmd             cmd_in;
    logic             wr_en;
    logic             rd_en;

    // classify the request
    always_comb begin
        cmd_in           = '0;
        cmd_in.echo      = i_echo_level;
        case (i_req_type)
            REQ_TICK:  cmd_in.start     = 1'b0;
            REQ_START: cmd_in.start     = 1'b1;
            REQ_FORCE: cmd_in.force_off = 1'b1;
            REQ_CLEAR: cmd_in.clr_ovr   = 1'b1;
            default:   cmd_in.start     = 1'b0;
        endcase
    end

    assign full      = (r_cnt == CNT_W'(Q_DEPTH));
    assign wr_en     = push && !full;
    assign o_cmd_vld = (r_cnt != '0);
    assign rd_en     = i_cmd_pop && o_cmd_vld;
    assign o_cmd     = r_mem[r_rd_ptr];

    // pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

    // fill count never exceeds the depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    // fill count rises by one on a write without a read
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a write");

    // both pointers meet when the queue is empty
    a_ptr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("pointers differ on empty queue");

endmodule

@@ hw/rtl/urrc_back.sv @@
// urrc_back: measurement sequencer, distance and percent arithmetic, relay
// hysteresis and result register; depends on urrc_pkg
module urrc_back #(
    parameter int COUNT_BITS = urrc_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  urrc_pkg::t_cfg    i_cfg,
    input  urrc_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_vld,
    output logic              o_cmd_pop,
    output urrc_pkg::t_result o_res,
    output logic              o_res_vld,
    input  logic              i_res_pop
);
    import urrc_pkg::*;

    localparam int P1_W = COUNT_BITS + C2D_W;
    localparam int HI_W = P1_W - D_SHIFT;
    localparam int P2_W = DIST_W + GAIN_W;

    t_seq                  r_seq, n_seq;
    t_phase                r_phase;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_relay;
    logic                  r_ovr;
    logic [DIST_W-1:0]     r_dist;
    logic [PCT_W-1:0]      r_pct;
    logic [COUNT_BITS-1:0] r_width;
    logic [P1_W-1:0]       r_prod1;
    logic [DIST_W-1:0]     r_dclamp;
    logic [P2_W-1:0]       r_prod2;
    t_result               r_res;
    logic                  r_res_vld;

    t_phase                s_phase;
    logic [COUNT_BITS-1:0] s_cnt;
    logic [COUNT_BITS-1:0] s_inc;
    logic [COUNT_BITS-1:0] s_base;
    logic                  s_relay;
    logic                  s_ovr;
    logic                  s_done;
    logic                  s_fin;

    logic [HI_W-1:0]       f_hi;
    logic [DIST_W-1:0]     f_dist;
    logic [DIST_W-1:0]     f_p;
    logic [PCT_W-1:0]      f_pct;
    logic                  f_ovr;
    logic                  f_relay;

    logic                  slot_free;
    logic                  take;
    logic                  fin_go;
    logic                  load_res;
    t_result               res_nxt;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        sat_inc = (c == '1) ? c : c + 1'b1;
    endfunction

    assign slot_free = !r_res_vld || i_res_pop;
    assign take      = (r_seq == SQ_STEP) && i_cmd_vld && slot_free;
    assign fin_go    = (r_seq == SQ_FIN) && slot_free;
    assign o_cmd_pop = take;

    // one tick of the measurement: request first, then the echo sample
    always_comb begin
        s_phase = r_phase;
        s_cnt   = r_cnt;
        s_relay = r_relay;
        s_ovr   = r_ovr;
        s_done  = 1'b0;
        s_fin   = 1'b0;
        s_base  = r_cnt;
        s_inc   = '0;
        if (i_cmd.start) begin
            if (r_phase == PH_IDLE) begin
                s_phase = PH_WAIT_LOW;
            end
        end else if (i_cmd.force_off) begin
            s_ovr   = 1'b1;
            s_relay = 1'b0;
        end else if (i_cmd.clr_ovr) begin
            s_ovr   = 1'b0;
        end
        case (s_phase)
            PH_IDLE: begin
                s_phase = PH_IDLE;
            end
            PH_WAIT_LOW: begin
                if (!i_cmd.echo) begin
                    s_phase = PH_TRIG_LOW;
                    s_cnt   = '0;
                end
            end
            PH_TRIG_LOW: begin
                s_inc = sat_inc(r_cnt);
                if (CMP_W'(s_inc) >= CMP_W'(i_cfg.trig_low)) begin
                    s_phase = PH_TRIG_HIGH;
                    s_cnt   = '0;
                end else begin
                    s_cnt   = s_inc;
                end
            end
            PH_TRIG_HIGH: begin
                s_inc = sat_inc(r_cnt);
                if (CMP_W'(s_inc) >= CMP_W'(i_cfg.trig_high)) begin
                    s_phase = PH_WAIT_HIGH;
                    s_cnt   = '0;
                end else begin
                    s_cnt   = s_inc;
                end
            end
            PH_WAIT_HIGH: begin
                s_base = i_cmd.echo ? '0 : r_cnt;
                if (CMP_W'(s_base) >= CMP_W'(i_cfg.timeout)) begin
                    s_phase = PH_IDLE;
                    s_cnt   = '0;
                    s_done  = 1'b1;
                end else begin
                    s_cnt = sat_inc(s_base);
                    if (i_cmd.echo) begin
                        s_phase = PH_MEASURE;
                    end
                end
            end
            PH_MEASURE: begin
                if (i_cmd.echo) begin
                    if (CMP_W'(r_cnt) >= CMP_W'(i_cfg.timeout)) begin
                        s_phase = PH_IDLE;
                        s_cnt   = '0;
                        s_done  = 1'b1;
                    end else begin
                        s_cnt = sat_inc(r_cnt);
                    end
                end else begin
                    s_done  = 1'b1;
                    s_fin   = (r_cnt != '0);
                    s_phase = PH_IDLE;
                    s_cnt   = '0;
                end
            end
            default: begin
                s_phase = PH_IDLE;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SQ_STEP: begin
                if (take && s_fin) begin
                    n_seq = SQ_MUL1;
                end
            end
            SQ_MUL1: n_seq = SQ_MUL2;
            SQ_MUL2: n_seq = SQ_FIN;
            SQ_FIN: begin
                if (slot_free) begin
                    n_seq = SQ_STEP;
                end
            end
            default: n_seq = SQ_STEP;
        endcase
    end

    // distance clamp, percent and relay hysteresis of a finished reading
    always_comb begin
        f_hi = r_prod1[P1_W-1:D_SHIFT];
        if (64'(f_hi) > 64'(DIST_MAX_Q4)) begin
            f_dist = DIST_MAX_Q4;
        end else if (64'(f_hi) < 64'(DIST_MIN_Q4)) begin
            f_dist = DIST_MIN_Q4;
        end else begin
            f_dist = DIST_W'(f_hi);
        end
        f_p   = r_prod2[P2_W-1:P_SHIFT];
        f_pct = (f_p > DIST_W'(PCT_FULL)) ? '0 : PCT_FULL - PCT_W'(f_p);
        f_ovr = r_ovr && !(r_dclamp < i_cfg.thr_low);
        f_relay = r_relay;
        if (!f_ovr) begin
            if ((r_dclamp > i_cfg.thr_high) && !r_relay) begin
                f_relay = 1'b1;
            end else if ((r_dclamp < i_cfg.thr_low) && r_relay) begin
                f_relay = 1'b0;
            end
        end
    end

    // result beat
    always_comb begin
        res_nxt = '0;
        if (r_seq == SQ_FIN) begin
            res_nxt.relay_on    = f_relay;
            res_nxt.override_on = f_ovr;
            res_nxt.done_res    = 1'b1;
            res_nxt.ok          = 1'b1;
            res_nxt.distance_q4 = r_dclamp;
            res_nxt.percent     = f_pct;
        end else begin
            res_nxt.trigger_out = (s_phase == PH_TRIG_HIGH);
            res_nxt.relay_on    = s_relay;
            res_nxt.override_on = s_ovr;
            res_nxt.busy_res    = (s_phase != PH_IDLE);
            res_nxt.done_res    = s_done;
            res_nxt.distance_q4 = r_dist;
            res_nxt.percent     = r_pct;
        end
        load_res = (take && !s_fin) || fin_go;
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= SQ_STEP;
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_relay   <= 1'b0;
            r_ovr     <= 1'b0;
            r_dist    <= '0;
            r_pct     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_seq <= n_seq;
            if (take) begin
                r_phase <= s_phase;
                r_cnt   <= s_cnt;
                r_relay <= s_relay;
                r_ovr   <= s_ovr;
            end
            if (fin_go) begin
                r_relay <= f_relay;
                r_ovr   <= f_ovr;
                r_dist  <= r_dclamp;
                r_pct   <= f_pct;
            end
            if (load_res) begin
                r_res_vld <= 1'b1;
            end else if (i_res_pop) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // reading datapath and result payload
    always_ff @(posedge i_clk) begin
        if (take && s_fin) begin
            r_width <= r_cnt;
        end
        if (r_seq == SQ_MUL1) begin
            r_prod1 <= P1_W'(r_width) * P1_W'(i_cfg.c2d);
        end
        if (r_seq == SQ_MUL2) begin
            r_dclamp <= f_dist;
            r_prod2  <= P2_W'(f_dist) * P2_W'(i_cfg.gain);
        end
        if (load_res) begin
            r_res <= res_nxt;
        end
    end

    // no command taken while a reading is being finished
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SQ_STEP) |-> !o_cmd_pop)
        else $error("command taken during reading");

    // override always holds the relay off
    a_ovr_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ovr && r_relay))
        else $error("relay on under override");

    // stored distance is zero or inside the clamp range
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dist == '0) || ((r_dist >= DIST_MIN_Q4) && (r_dist <= DIST_MAX_Q4)))
        else $error("distance outside clamp range");

    // a reading steps through SQ_MUL1, SQ_MUL2 and SQ_FIN in turn once it starts
    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && s_fin) |=> (r_seq == SQ_MUL1) ##1 (r_seq == SQ_MUL2) ##1 (r_seq == SQ_FIN))
        else $error("reading sequence broken");

endmodule

@@ hw/rtl/ultrasonic_ranger_relay_control.sv @@
// ultrasonic_ranger_relay_control: top level of the ranger with relay control;
// holds the configuration registers, instantiates urrc_front and urrc_back
//
// channel   direction  handshake                  payload
// input     in         push / full                i_req_type, i_echo_level
// result    out        empty / pop                o_trigger_out .. o_percent
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one result beat per input beat; a tick is handled in the step state of the back end,
// a tick that ends a valid reading goes on through two registered multiplies
// and the relay update, so up to Q_DEPTH beats queue in front meanwhile.
// synchronous active-low reset clears the queue, phase, relay and override.
// a full result register stalls the back end; the input queue keeps taking
// beats until it fills. config is always ready.
module ultrasonic_ranger_relay_control #(
    parameter int COUNT_BITS = urrc_pkg::COUNT_BITS_DEF,
    parameter int Q_DEPTH    = urrc_pkg::Q_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [urrc_pkg::REQ_W-1:0]     i_req_type,
    input  logic                           i_echo_level,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_trigger_out,
    output logic                           o_relay_on,
    output logic                           o_override_on,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_ok,
    output logic [urrc_pkg::DIST_W-1:0]    o_distance_q4,
    output logic [urrc_pkg::PCT_W-1:0]     o_percent,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [urrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [urrc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import urrc_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    logic    cmd_vld;
    logic    cmd_pop;
    t_result res;
    logic    res_vld;
    logic    cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c2d       <= C2D_RST;
            r_cfg.trig_low  <= TRIG_LOW_RST;
            r_cfg.trig_high <= TRIG_HIGH_RST;
            r_cfg.timeout   <= TIMEOUT_RST;
            r_cfg.thr_low   <= THR_LOW_RST;
            r_cfg.thr_high  <= THR_HIGH_RST;
            r_cfg.gain      <= GAIN_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_C2D:       r_cfg.c2d       <= i_cfg_data[C2D_W-1:0];
                CFG_TRIG_LOW:  r_cfg.trig_low  <= i_cfg_data[TRIG_W-1:0];
                CFG_TRIG_HIGH: r_cfg.trig_high <= i_cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT:   r_cfg.timeout   <= i_cfg_data[TMO_W-1:0];
                CFG_THR_LOW:   r_cfg.thr_low   <= i_cfg_data[DIST_W-1:0];
                CFG_THR_HIGH:  r_cfg.thr_high  <= i_cfg_data[DIST_W-1:0];
                CFG_GAIN:      r_cfg.gain      <= i_cfg_data[GAIN_W-1:0];
                default:       r_cfg.gain      <= r_cfg.gain;
            endcase
        end
    end

    // input queue and request decode
    urrc_front #(
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_echo_level (i_echo_level),
        .o_cmd        (cmd),
        .o_cmd_vld    (cmd_vld),
        .i_cmd_pop    (cmd_pop)
    );

    // measurement engine
    urrc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .i_cmd_vld (cmd_vld),
        .o_cmd_pop (cmd_pop),
        .o_res     (res),
        .o_res_vld (res_vld),
        .i_res_pop (pop)
    );

    // result ports
    assign empty         = !res_vld;
    assign o_trigger_out = res.trigger_out;
    assign o_relay_on    = res.relay_on;
    assign o_override_on = res.override_on;
    assign o_busy_res    = res.busy_res;
    assign o_done_res    = res.done_res;
    assign o_ok          = res.ok;
    assign o_distance_q4 = res.distance_q4;
    assign o_percent     = res.percent;

endmodule

@@ tb/ultrasonic_ranger_relay_control_tb.sv @@
`timescale 1ns / 1ps
// ultrasonic_ranger_relay_control_tb: self-checking bench for the ranger and relay control
// feeds tick beats through push/full, checks each result beat against a tick-level
// predictor of the ranger; depends on urrc_pkg and ultrasonic_ranger_relay_control
module ultrasonic_ranger_relay_control_tb;
    import urrc_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int HOLD_AT_BEAT    = 700;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASE_BEATS     = 200;
    localparam int PRINT_CAP       = 40;
    localparam logic [CFG_IDX_W-1:0]      CFG_UNUSED = 3'd7;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX  = '1;

    // one tick beat, with a hand-written expectation where typed is set
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             echo;
        logic             typed;
        t_result          want;
    } t_tick;

    localparam t_result IDLE_ST = '0;
    localparam t_result OVR_ST  = '{override_on: 1'b1, default: '0};
    localparam t_result BUSY_ST = '{busy_res: 1'b1, default: '0};
    localparam t_result TRIG_ST = '{trigger_out: 1'b1, busy_res: 1'b1, default: '0};

    // directed ticks, run with trigger 1/1, timeout 8, thresholds 40/100, max scale
    localparam int N_DIRECTED = 21;
    localparam t_tick DIRECTED_ROWS [N_DIRECTED] = '{
        '{REQ_TICK,  1'b0, 1'b1, IDLE_ST},  // first beat after reset
        '{REQ_FORCE, 1'b1, 1'b1, OVR_ST},   // override on, relay off
        '{REQ_CLEAR, 1'b0, 1'b1, IDLE_ST},
        '{REQ_START, 1'b1, 1'b1, BUSY_ST},  // echo still high, keep waiting
        '{REQ_START, 1'b1, 1'b1, BUSY_ST},  // start while busy is dropped
        '{REQ_TICK,  1'b0, 1'b1, BUSY_ST},  // echo low, trigger low phase
        '{REQ_TICK,  1'b1, 1'b1, TRIG_ST},  // trigger pulse
        '{REQ_TICK,  1'b0, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},  // echo rises, width counts from 1
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b0, 1'b0, IDLE_ST},  // width 7, above high threshold
        '{REQ_START, 1'b0, 1'b0, IDLE_ST},  // start on echo low goes straight on
        '{REQ_TICK,  1'b0, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},
        '{REQ_TICK,  1'b1, 1'b0, IDLE_ST},
        '{REQ_FORCE, 1'b0, 1'b0, IDLE_ST}   // force off and a short reading together
    };

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   push         = 1'b0;
    logic [REQ_W-1:0]       i_req_type   = REQ_TICK;
    logic                   i_echo_level = 1'b0;
    logic                   pop          = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index  = CFG_C2D;
    logic [CFG_DAT_W-1:0]   i_cfg_data   = '0;
    logic                   full;
    logic                   empty;
    logic                   o_trigger_out;
    logic                   o_relay_on;
    logic                   o_override_on;
    logic                   o_busy_res;
    logic                   o_done_res;
    logic                   o_ok;
    logic [DIST_W-1:0]      o_distance_q4;
    logic [PCT_W-1:0]       o_percent;
    logic                   o_cfg_ready;

    ultrasonic_ranger_relay_control i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_echo_level  (i_echo_level),
        .empty         (empty),
        .pop           (pop),
        .o_trigger_out (o_trigger_out),
        .o_relay_on    (o_relay_on),
        .o_override_on (o_override_on),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_ok          (o_ok),
        .o_distance_q4 (o_distance_q4),
        .o_percent     (o_percent),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predicted ranger state and register copy
    t_cfg                      cfg_now;
    t_phase                    ph_now;
    logic [COUNT_BITS_DEF-1:0] width_cnt;
    logic                      relay_now;
    logic                      ovr_now;
    logic [DIST_W-1:0]         dist_now;
    logic [PCT_W-1:0]          pct_now;

    t_tick   pending_ticks[$];
    t_result expected_status[$];
    int      errors       = 0;
    int      results_seen = 0;
    int      stall_cycles = 0;
    int      queued_beats = 0;
    bit      steady       = 1'b0;
    bit      in_beat      = 1'b0;
    bit      out_beat     = 1'b0;

    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [COUNT_BITS_DEF-1:0] bump(logic [COUNT_BITS_DEF-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // one tick of the ranger: request first, then the echo sample
    function automatic t_result advance_ranger(logic [REQ_W-1:0] req, logic echo);
        logic        done;
        logic        good;
        logic [63:0] d;
        logic [63:0] p;
        t_result     r;
        done = 1'b0;
        good = 1'b0;
        case (req)
            REQ_START: if (ph_now == PH_IDLE) ph_now = PH_WAIT_LOW;
            REQ_FORCE: begin
                ovr_now   = 1'b1;
                relay_now = 1'b0;
            end
            REQ_CLEAR: ovr_now = 1'b0;
            default: ;
        endcase
        case (ph_now)
            PH_WAIT_LOW: if (!echo) begin
                ph_now    = PH_TRIG_LOW;
                width_cnt = '0;
            end
            PH_TRIG_LOW: begin
                width_cnt = bump(width_cnt);
                if (width_cnt >= COUNT_BITS_DEF'(cfg_now.trig_low)) begin
                    ph_now    = PH_TRIG_HIGH;
                    width_cnt = '0;
                end
            end
            PH_TRIG_HIGH: begin
                width_cnt = bump(width_cnt);
                if (width_cnt >= COUNT_BITS_DEF'(cfg_now.trig_high)) begin
                    ph_now    = PH_WAIT_HIGH;
                    width_cnt = '0;
                end
            end
            PH_WAIT_HIGH: begin
                if (echo) width_cnt = '0;
                if (width_cnt >= cfg_now.timeout) begin
                    ph_now    = PH_IDLE;
                    width_cnt = '0;
                    done      = 1'b1;
                end else begin
                    width_cnt = bump(width_cnt);
                    if (echo) ph_now = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    if (width_cnt >= cfg_now.timeout) begin
                        ph_now    = PH_IDLE;
                        width_cnt = '0;
                        done      = 1'b1;
                    end else begin
                        width_cnt = bump(width_cnt);
                    end
                end else begin
                    done = 1'b1;
                    // echo fell: width to distance, percent, then hysteresis
                    if (width_cnt != '0) begin
                        d = (64'(width_cnt) * 64'(cfg_now.c2d)) >> D_SHIFT;
                        if (d > 64'(DIST_MAX_Q4)) d = 64'(DIST_MAX_Q4);
                        if (d < 64'(DIST_MIN_Q4)) d = 64'(DIST_MIN_Q4);
                        p = (d * 64'(cfg_now.gain)) >> P_SHIFT;
                        dist_now = d[DIST_W-1:0];
                        pct_now  = (p > 64'(PCT_FULL)) ? '0 : PCT_FULL - p[PCT_W-1:0];
                        if (ovr_now && d < 64'(cfg_now.thr_low)) ovr_now = 1'b0;
                        if (!ovr_now) begin
                            if (d > 64'(cfg_now.thr_high) && !relay_now) relay_now = 1'b1;
                            else if (d < 64'(cfg_now.thr_low) && relay_now) relay_now = 1'b0;
                        end
                        good = 1'b1;
                    end
                    ph_now    = PH_IDLE;
                    width_cnt = '0;
                end
            end
            default: ph_now = PH_IDLE;
        endcase
        r.trigger_out = (ph_now == PH_TRIG_HIGH);
        r.relay_on    = relay_now;
        r.override_on = ovr_now;
        r.busy_res    = (ph_now != PH_IDLE);
        r.done_res    = done;
        r.ok          = good;
        r.distance_q4 = dist_now;
        r.percent     = pct_now;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got,
                     want);
        errors++;
    endtask

    // one register write beat; valid stays up for a following write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_C2D:       cfg_now.c2d       = data[C2D_W-1:0];
            CFG_TRIG_LOW:  cfg_now.trig_low  = data[TRIG_W-1:0];
            CFG_TRIG_HIGH: cfg_now.trig_high = data[TRIG_W-1:0];
            CFG_TIMEOUT:   cfg_now.timeout   = data[TMO_W-1:0];
            CFG_THR_LOW:   cfg_now.thr_low   = data[DIST_W-1:0];
            CFG_THR_HIGH:  cfg_now.thr_high  = data[DIST_W-1:0];
            CFG_GAIN:      cfg_now.gain      = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_DAT_W-1:0] c2d, tl, th, tmo, lo, hi, gain);
        cfg_write(CFG_C2D, c2d);
        cfg_write(CFG_TRIG_LOW, tl);
        cfg_write(CFG_TRIG_HIGH, th);
        cfg_write(CFG_TIMEOUT, tmo);
        cfg_write(CFG_THR_LOW, lo);
        cfg_write(CFG_THR_HIGH, hi);
        cfg_write(CFG_GAIN, gain);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [REQ_W-1:0] side_request();
        int r;
        r = $urandom_range(99);
        if (r < 88) return REQ_TICK;
        if (r < 93) return REQ_FORCE;
        if (r < 97) return REQ_CLEAR;
        return REQ_START;
    endfunction

    function automatic void add_tick(logic [REQ_W-1:0] req, logic echo);
        t_tick t;
        t      = '0;
        t.req  = req;
        t.echo = echo;
        pending_ticks.push_back(t);
        queued_beats++;
    endfunction

    // a full measurement: echo-low wait, trigger, echo wait, echo width
    function automatic void add_measurement();
        int pre;
        int gap;
        int span;
        int lim;
        lim = (int'(cfg_now.timeout) > 30) ? 30 : int'(cfg_now.timeout);
        pre = $urandom_range(3);
        add_tick(REQ_START, pre != 0);
        for (int i = 1; i < pre; i++) add_tick(side_request(), 1'b1);
        if (pre != 0) add_tick(side_request(), 1'b0);
        span = ((cfg_now.trig_low == '0) ? 1 : int'(cfg_now.trig_low)) +
               ((cfg_now.trig_high == '0) ? 1 : int'(cfg_now.trig_high));
        for (int i = 0; i < span; i++) add_tick(side_request(), 1'($urandom));
        // a gap past the limit ends in an echo timeout
        gap = $urandom_range(lim + 1);
        for (int i = 0; i < gap; i++) add_tick(side_request(), 1'b0);
        if (int'(cfg_now.timeout) >= 450 && $urandom_range(15) == 0)
            span = $urandom_range(450, 100);
        else span = $urandom_range(lim + 1, 1);
        for (int i = 0; i < span; i++) add_tick(side_request(), 1'b1);
        add_tick(side_request(), 1'b0);
    endfunction

    function automatic void add_noise();
        int n;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) add_tick(REQ_W'($urandom_range(3)), 1'($urandom));
    endfunction

    // wait until every queued tick has come back, then let the pipe settle
    task automatic drain();
        while (pending_ticks.size() != 0 || expected_status.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase();
        int mark;
        mark = queued_beats;
        while (queued_beats - mark < PHASE_BEATS) begin
            if ($urandom_range(9) < 8) add_measurement();
            else add_noise();
        end
        drain();
    endtask

    // input side: hold a beat until taken, idle at random
    initial begin : feed_ticks
        forever begin
            @(negedge i_clk);
            if (!push || in_beat) begin
                if (i_rst_n && pending_ticks.size() != 0 &&
                    (steady || $urandom_range(99) >= 33)) begin
                    push         <= 1'b1;
                    i_req_type   <= pending_ticks[0].req;
                    i_echo_level <= pending_ticks[0].echo;
                end else begin
                    push         <= 1'b0;
                    i_req_type   <= REQ_W'($urandom);
                    i_echo_level <= 1'($urandom);
                end
            end
        end
    end

    // result side: random pop, one long hold-off to back up the input
    initial begin : take_results
        bit held;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AT_BEAT && pending_ticks.size() > 40) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                pop <= steady || ($urandom_range(99) >= 33);
            end
        end
    end

    // beat monitor: predict on input beats, compare on result beats
    always @(posedge i_clk) begin : beat_monitor
        t_tick   t;
        t_result got;
        t_result want;
        in_beat  = i_rst_n && push && !full;
        out_beat = i_rst_n && pop && !empty;
        if (in_beat) begin
            t    = pending_ticks.pop_front();
            want = advance_ranger(t.req, t.echo);
            expected_status.push_back(t.typed ? t.want : want);
        end
        if (out_beat) begin
            got = '{o_trigger_out, o_relay_on, o_override_on, o_busy_res, o_done_res, o_ok,
                    o_distance_q4, o_percent};
            results_seen++;
            if (expected_status.size() == 0) begin
                report_mismatch("result beat with nothing expected", 1, 0);
            end else begin
                want = expected_status.pop_front();
                if (got.trigger_out !== want.trigger_out)
                    report_mismatch("trigger_out", got.trigger_out, want.trigger_out);
                if (got.relay_on !== want.relay_on)
                    report_mismatch("relay_on", got.relay_on, want.relay_on);
                if (got.override_on !== want.override_on)
                    report_mismatch("override_on", got.override_on, want.override_on);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", got.done_res, want.done_res);
                if (got.ok !== want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.distance_q4 !== want.distance_q4)
                    report_mismatch("distance_q4", got.distance_q4, want.distance_q4);
                if (got.percent !== want.percent)
                    report_mismatch("percent", got.percent, want.percent);
            end
        end
        stall_cycles = (in_beat || out_beat || (i_cfg_valid && o_cfg_ready)) ? 0
                                                                              : stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < WATCHDOG_CYCLES) @(posedge i_clk);
        $display("no beat moved for %0d cycles", WATCHDOG_CYCLES);
        $display("Verification failed");
        $finish;
    end

    initial begin : main_seq
        int lo;
        ph_now    = PH_IDLE;
        width_cnt = '0;
        relay_now = 1'b0;
        ovr_now   = 1'b0;
        dist_now  = '0;
        pct_now   = '0;
        cfg_now   = '{C2D_RST, TRIG_LOW_RST, TRIG_HIGH_RST, TIMEOUT_RST, THR_LOW_RST,
                      THR_HIGH_RST, GAIN_RST};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks with short trigger and full-scale distance
        write_all(20'hFFFF, 20'd1, 20'd1, 20'd8, 20'd40, 20'd100, 20'(GAIN_RST));
        for (int i = 0; i < N_DIRECTED; i++) pending_ticks.push_back(DIRECTED_ROWS[i]);
        drain();

        // lowest settings: distance pinned at the clamp, instant timeouts
        write_all(20'd1, 20'd1, 20'd1, 20'd1, 20'd0, 20'd0, 20'd0);
        run_phase();

        // highest settings: long widths reach the upper clamp
        write_all(20'hFFFF, 20'd2, 20'd1, 20'hFFFFF, 20'(DIST_MAX_Q4), 20'(DIST_MAX_Q4),
                  20'hFFFF);
        run_phase();

        // power-on settings
        write_all(20'(C2D_RST), 20'(TRIG_LOW_RST), 20'(TRIG_HIGH_RST), 20'(TIMEOUT_RST),
                  20'(THR_LOW_RST), 20'(THR_HIGH_RST), 20'(GAIN_RST));
        run_phase();

        // unused index, upper data bits dropped, zero timeout
        cfg_write(CFG_UNUSED, 20'($urandom));
        lo = $urandom_range(400);
        write_all(20'hF0000 | 20'($urandom_range(65535, 4096)),
                  20'hF0000 | 20'($urandom_range(3, 1)),
                  20'hA0000 | 20'($urandom_range(3, 1)),
                  20'h0,
                  20'hFE000 | 20'(lo),
                  20'hFE000 | 20'($urandom_range(lo + 400, lo)),
                  20'h50000 | 20'($urandom_range(65535)));
        run_phase();

        // random settings, one phase with no idling on either side
        for (int k = 0; k < 4; k++) begin
            lo = $urandom_range(400);
            write_all(20'($urandom_range(65535, 4096)), 20'($urandom_range(6, 1)),
                      20'($urandom_range(6, 1)), 20'($urandom_range(40, 1)), 20'(lo),
                      20'($urandom_range(lo + 400, lo)), 20'($urandom_range(65535)));
            steady = (k == 1);
            run_phase();
        end
        steady = 1'b0;
        drain();

        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
